FILE: src/zbba_pkg.sv
// Shared constants, codes and types for the zone bitmap block allocator.
`default_nettype none

package zbba_pkg;

    // WORD_BITS must be a power of two: bit positions split into word and offset fields.
    localparam int MAP_BITS  = 8192;
    localparam int WORD_BITS = 32;
    localparam int NUM_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BOFF_W    = $clog2(WORD_BITS);
    localparam int BITI_W    = WIDX_W + BOFF_W;

    localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(NUM_WORDS - 1);

    typedef logic [WORD_BITS-1:0] t_word;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NO_SPACE     = 2'd1,
        ST_OUT_OF_RANGE = 2'd2,
        ST_ALREADY_FREE = 2'd3
    } t_status;

    localparam logic [1:0] CFG_FIRST_DATA_ZONE = 2'd0;
    localparam logic [1:0] CFG_ZONE_COUNT      = 2'd1;
    localparam logic [1:0] CFG_MAP_BITS_IN_USE = 2'd2;

    localparam logic [13:0] MAP_BITS_RESET = 14'd8192;

endpackage

`default_nettype wire

FILE: src/zbba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module zbba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: src/zone_bitmap_block_allocator_core.sv
// Top level of the zone bitmap block allocator: sequencer, word scan and bitmap RAM.
//
//  channel   handshake            payload
//  -------   ------------------   ---------------------------------------------------
//  command   start, busy          i_op, i_block_number
//  config    i_cfg_we             i_cfg_idx, i_cfg_data
//  result    o_valid (1 cycle)    o_status, o_allocated_block, o_changed,
//                                 o_word_index, o_word_value
//
// Allocate scans one bitmap word per cycle through the RAM read port until a word
// holds a clear bit, then checks it against the bits in use and writes it back; a
// full map ends at the last word. Free does a range check, then a word read and
// write-back, and stops after the check when out of range. The result beat comes
// in the cycle in which busy drops and a new command is taken in that same cycle.
// Reset clears per-word valid bits at once, so no clearing pass is needed;
// a word never written reads as all clear. The receiver cannot stall a beat.
`default_nettype none

module zone_bitmap_block_allocator_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_op,
    input  wire logic [31:0] i_block_number,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    output logic             o_valid,
    output logic [1:0]       o_status,
    output logic [31:0]      o_allocated_block,
    output logic             o_changed,
    output logic [7:0]       o_word_index,
    output logic [31:0]      o_word_value
);

    import zbba_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_ACHK = 5'b00100,
        S_FCHK = 5'b01000,
        S_FRD  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [31:0] r_first_data_zone;
    logic [31:0] r_zone_count;
    logic [13:0] r_map_bits_in_use;

    logic [WIDX_W-1:0] r_w, n_w;
    logic [BOFF_W-1:0] r_b, n_b;
    t_word             r_word, n_word;
    logic [31:0]       r_blk;

    logic [NUM_WORDS-1:0] r_vld;
    logic                 r_rd_vld;

    // result beat registers
    logic        r_valid, n_valid;
    t_status     r_status, n_status;
    logic [31:0] r_alloc, n_alloc;
    logic        r_changed, n_changed;
    logic [7:0]  r_widx, n_widx;
    logic [31:0] r_wval, n_wval;

    // RAM ports
    logic              ram_we;
    logic [WIDX_W-1:0] ram_raddr;
    t_word             ram_wdata;
    t_word             ram_rdata;
    t_word             rd_word;

    // shared compute signals
    logic              accept;
    logic [BOFF_W-1:0] ffz;
    logic              full;
    logic [BITI_W-1:0] abit;
    logic [31:0]       limit;
    logic [31:0]       ablk;
    logic [32:0]       fbit;
    logic              frange_bad;
    logic [15:0]       widx16;
    logic [63:0]       wval64;

    zbba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_w),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // unwritten words read as clear
    assign rd_word = r_rd_vld ? ram_rdata : '0;
    assign full    = (rd_word == '1);

    always_comb begin
        ffz = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!rd_word[i]) begin
                ffz = BOFF_W'(i);
            end
        end
    end

    assign limit = (32'(r_map_bits_in_use) > 32'(MAP_BITS)) ? 32'(MAP_BITS)
                                                            : 32'(r_map_bits_in_use);
    assign abit  = {r_w, r_b};
    assign ablk  = 32'(abit) + r_first_data_zone - 32'd1;

    assign frange_bad = (r_blk < r_first_data_zone) || (r_blk >= r_zone_count);
    assign fbit       = {1'b0, r_blk} - {1'b0, r_first_data_zone} + 33'd1;

    assign widx16 = 16'(r_w);
    assign wval64 = 64'(ram_wdata);

    always_comb begin
        n_state   = r_state;
        n_w       = r_w;
        n_b       = r_b;
        n_word    = r_word;
        n_valid   = 1'b0;
        n_status  = ST_OK;
        n_alloc   = '0;
        n_changed = 1'b0;
        n_widx    = '0;
        n_wval    = '0;
        ram_we    = 1'b0;
        ram_wdata = r_word;
        ram_raddr = r_w;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_op == OP_ALLOC) begin
                        n_w       = '0;
                        ram_raddr = '0;
                        n_state   = S_SCAN;
                    end else begin
                        n_state = S_FCHK;
                    end
                end
            end
            S_SCAN: begin
                if (!full) begin
                    n_b     = ffz;
                    n_word  = rd_word | (t_word'(1) << ffz);
                    n_state = S_ACHK;
                end else if (r_w == LAST_WORD) begin
                    n_valid  = 1'b1;
                    n_status = ST_NO_SPACE;
                    n_state  = S_IDLE;
                end else begin
                    // advance to the next word; its data lands next cycle
                    n_w       = r_w + WIDX_W'(1);
                    ram_raddr = r_w + WIDX_W'(1);
                end
            end
            S_ACHK: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
                if (32'(abit) >= limit) begin
                    n_status = ST_NO_SPACE;
                end else begin
                    ram_we    = 1'b1;
                    ram_wdata = r_word;
                    n_changed = 1'b1;
                    n_widx    = widx16[7:0];
                    n_wval    = wval64[31:0];
                    // bit stays set even when the block lands outside the zones
                    if ((ablk < r_first_data_zone) || (ablk >= r_zone_count)) begin
                        n_status = ST_OUT_OF_RANGE;
                    end else begin
                        n_alloc = ablk;
                    end
                end
            end
            S_FCHK: begin
                if (frange_bad || (fbit >= 33'(MAP_BITS))) begin
                    n_valid  = 1'b1;
                    n_status = ST_OUT_OF_RANGE;
                    n_state  = S_IDLE;
                end else begin
                    n_w       = fbit[BITI_W-1:BOFF_W];
                    n_b       = fbit[BOFF_W-1:0];
                    ram_raddr = fbit[BITI_W-1:BOFF_W];
                    n_state   = S_FRD;
                end
            end
            S_FRD: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
                if (!rd_word[r_b]) begin
                    n_status = ST_ALREADY_FREE;
                end else begin
                    ram_we    = 1'b1;
                    ram_wdata = rd_word & ~(t_word'(1) << r_b);
                    n_changed = 1'b1;
                    n_widx    = widx16[7:0];
                    n_wval    = wval64[31:0];
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_IDLE;
            r_valid           <= 1'b0;
            r_vld             <= '0;
            r_rd_vld          <= 1'b0;
            r_first_data_zone <= '0;
            r_zone_count      <= '0;
            r_map_bits_in_use <= MAP_BITS_RESET;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_rd_vld <= r_vld[ram_raddr];
            if (ram_we) begin
                r_vld[r_w] <= 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FIRST_DATA_ZONE: r_first_data_zone <= i_cfg_data;
                    CFG_ZONE_COUNT:      r_zone_count      <= i_cfg_data;
                    CFG_MAP_BITS_IN_USE: r_map_bits_in_use <= i_cfg_data[13:0];
                    default: begin
                        // drop writes beyond the register list
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_w       <= n_w;
        r_b       <= n_b;
        r_word    <= n_word;
        r_status  <= n_status;
        r_alloc   <= n_alloc;
        r_changed <= n_changed;
        r_widx    <= n_widx;
        r_wval    <= n_wval;
        if (accept) begin
            r_blk <= i_block_number;
        end
    end

    assign o_valid           = r_valid;
    assign o_status          = r_status;
    assign o_allocated_block = r_alloc;
    assign o_changed         = r_changed;
    assign o_word_index      = r_widx;
    assign o_word_value      = r_wval;

endmodule

`default_nettype wire
